FILE: rtl/tccw_pkg.sv
// package for the text console cell writer: geometry, codes and address helpers
package tccw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int LIN_W  = 12;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = ATTR_W + CHAR_W;
   localparam int OP_W   = 3;

   // character handling
   localparam int                TAB_STOP    = 8;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
   localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
   localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT_CHAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT_AT     = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ROW  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd5;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_FILL,
      ST_SCROLL,
      ST_SCROLL_END,
      ST_DONE
   } state_type;

   // linear position row * COLUMNS + col
   function automatic logic [LIN_W-1:0] cell_lin(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      cell_lin = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
   endfunction

   // memory address of a cell
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      logic [LIN_W-1:0] lin;
      lin = cell_lin(r, c);
      cell_addr = lin[ADDR_W-1:0];
   endfunction

endpackage

FILE: rtl/tccw_ram.sv
// generic single write port, single read port ram with registered read
module tccw_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 2000,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/text_console_cell_writer.sv
// text console cell writer: screen memory, cursor and operation sequencer
//
// Requests enter on req_valid/req_ready and carry one operation each; every
// request yields exactly one response on rsp_valid/rsp_ready with the cursor
// after the operation, its linear position and, for read cell, the cell.
// csr_wr_en/csr_wr_data set the attribute byte for printed and blank cells;
// write it only while no request is in flight.
// Steps, from the accepting edge to rsp_valid: put char (no scroll), put at,
// set cursor and unused codes load the response straight from decode, and a
// new request is taken only back in idle. Read cell steps through address,
// read data capture and response load. Clear row walks one row, one cell a
// cycle; clear screen walks the whole screen. A put char that runs off the
// last row copies every row up through the registered read port, one cell a
// cycle, then blanks the last row.
// After reset the screen memory is filled with blank cells of attribute 7,
// one cell a cycle; req_ready stays low until that pass ends, while
// configuration writes are taken at once.
// A response waits in its output register while rsp_ready is low; the next
// request is still accepted and runs up to its own response, which then waits.
module text_console_cell_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tccw_pkg::OP_W-1:0]     req_opcode,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::COL_W-1:0]    req_col,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row,
   input  logic [tccw_pkg::ATTR_W-1:0]   req_cell_attr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tccw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tccw_pkg::LIN_W-1:0]    rsp_cursor_linear,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_cell_word,
   input  logic                          csr_wr_en,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_wr_data
);

   import tccw_pkg::*;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [ATTR_W-1:0]  text_attr_ff;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [CELL_W-1:0]  word_ff, word_in;
   logic [ADDR_W-1:0]  fill_addr_ff, fill_addr_in;
   logic [ADDR_W-1:0]  fill_last_ff, fill_last_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [LIN_W-1:0]   rsp_lin_ff, rsp_lin_in;
   logic [CELL_W-1:0]  rsp_word_ff, rsp_word_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_wa;
   logic [CELL_W-1:0]  ram_wd;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_ra;
   logic [CELL_W-1:0]  ram_rd_data;

   // screen memory
   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_data)
   );

   // sequencer and datapath
   always_comb begin
      logic [CELL_W-1:0] blank;
      logic              xok;
      logic              yok;
      logic              out_free;
      logic              finish;
      logic [COL_W:0]    col_inc;
      logic [COL_W:0]    tab_col;
      logic [ROW_W:0]    row_adv;
      logic [ROW_W:0]    row_n;

      blank    = {text_attr_ff, CH_SPACE};
      xok      = {1'b0, col_ff} < (COL_W + 1)'(COLUMNS);
      yok      = {1'b0, row_ff} < (ROW_W + 1)'(ROWS);
      out_free = !rsp_valid_ff || rsp_ready;
      finish   = 1'b0;
      col_inc  = {1'b0, cur_col_ff} + (COL_W + 1)'(1);
      tab_col  = ({1'b0, cur_col_ff} + (COL_W + 1)'(TAB_STOP))
                 & ~((COL_W + 1)'(TAB_STOP - 1));
      row_adv  = {1'b0, cur_row_ff} + (ROW_W + 1)'(1);
      row_n    = {1'b0, cur_row_ff};

      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      op_in        = op_ff;
      char_in      = char_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = attr_ff;
      word_in      = word_ff;
      fill_addr_in = fill_addr_ff;
      fill_last_in = fill_last_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_word_in  = rsp_word_ff;

      ram_re = 1'b0;
      ram_ra = '0;
      // pending scroll copy write
      ram_we = pend_ff;
      ram_wa = pend_addr_ff;
      ram_wd = ram_rd_data;

      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         // clearing pass after reset
         ST_INIT: begin
            ram_we       = 1'b1;
            ram_wa       = fill_addr_ff;
            ram_wd       = RESET_BLANK;
            fill_addr_in = fill_addr_ff + ADDR_W'(1);
            if (fill_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               fill_addr_in = '0;
               state_in     = ST_IDLE;
            end
         end

         // take a request
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               char_in  = req_char_code;
               col_in   = req_col;
               row_in   = req_row;
               attr_in  = req_cell_attr;
               state_in = ST_EXEC;
            end
         end

         // decode and do the single-cycle part of the operation
         ST_EXEC: begin
            word_in = '0;
            finish  = 1'b1;
            case (op_ff)
               OP_PUT_CHAR: begin
                  if (char_ff == CH_LF) begin
                     cur_col_in = '0;
                     row_n      = row_adv;
                  end else if (char_ff == CH_CR) begin
                     cur_col_in = '0;
                  end else if (char_ff == CH_TAB) begin
                     if (tab_col >= (COL_W + 1)'(COLUMNS)) begin
                        cur_col_in = '0;
                        row_n      = row_adv;
                     end else begin
                        cur_col_in = tab_col[COL_W-1:0];
                     end
                  end else if (char_ff == CH_BS) begin
                     if (cur_col_ff != '0) begin
                        cur_col_in = cur_col_ff - COL_W'(1);
                        ram_we     = 1'b1;
                        ram_wa     = cell_addr(cur_row_ff, cur_col_ff - COL_W'(1));
                        ram_wd     = blank;
                     end
                  end else if (!char_ff[CHAR_W-1] && char_ff >= CH_SPACE) begin
                     ram_we = 1'b1;
                     ram_wa = cell_addr(cur_row_ff, cur_col_ff);
                     ram_wd = {text_attr_ff, char_ff};
                     if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
                        cur_col_in = '0;
                        row_n      = row_adv;
                     end else begin
                        cur_col_in = col_inc[COL_W-1:0];
                     end
                  end
                  // scroll when the cursor runs off the last row
                  if (row_n >= (ROW_W + 1)'(ROWS)) begin
                     cur_row_in   = ROW_W'(ROWS - 1);
                     fill_addr_in = ADDR_W'(COLUMNS);
                     finish       = 1'b0;
                     state_in     = ST_SCROLL;
                  end else begin
                     cur_row_in = row_n[ROW_W-1:0];
                  end
               end
               OP_PUT_AT: begin
                  if (xok && yok) begin
                     ram_we = 1'b1;
                     ram_wa = cell_addr(row_ff, col_ff);
                     ram_wd = {attr_ff, char_ff};
                  end
               end
               OP_SET_CURSOR: begin
                  if (xok) begin
                     cur_col_in = col_ff;
                  end
                  if (yok) begin
                     cur_row_in = row_ff;
                  end
               end
               OP_CLEAR: begin
                  cur_col_in   = '0;
                  cur_row_in   = '0;
                  fill_addr_in = '0;
                  fill_last_in = ADDR_W'(CELL_COUNT - 1);
                  finish       = 1'b0;
                  state_in     = ST_FILL;
               end
               OP_CLEAR_ROW: begin
                  if (yok) begin
                     fill_addr_in = cell_addr(row_ff, '0);
                     fill_last_in = cell_addr(row_ff, '0) + ADDR_W'(COLUMNS - 1);
                     finish       = 1'b0;
                     state_in     = ST_FILL;
                  end
               end
               OP_READ_CELL: begin
                  if (xok && yok) begin
                     ram_re   = 1'b1;
                     ram_ra   = cell_addr(row_ff, col_ff);
                     finish   = 1'b0;
                     state_in = ST_READ;
                  end
               end
               default: begin
               end
            endcase
            // respond at once when the output register is free
            if (finish) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_col_in   = cur_col_in;
                  rsp_row_in   = cur_row_in;
                  rsp_lin_in   = cell_lin(cur_row_in, cur_col_in);
                  rsp_word_in  = '0;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // capture read data
         ST_READ: begin
            word_in  = ram_rd_data;
            state_in = ST_DONE;
         end

         // blank a run of cells
         ST_FILL: begin
            ram_we       = 1'b1;
            ram_wa       = fill_addr_ff;
            ram_wd       = blank;
            fill_addr_in = fill_addr_ff + ADDR_W'(1);
            if (fill_addr_ff == fill_last_ff) begin
               state_in = ST_DONE;
            end
         end

         // copy each cell one row up: read now, write next cycle
         ST_SCROLL: begin
            ram_re       = 1'b1;
            ram_ra       = fill_addr_ff;
            pend_in      = 1'b1;
            pend_addr_in = fill_addr_ff - ADDR_W'(COLUMNS);
            fill_addr_in = fill_addr_ff + ADDR_W'(1);
            if (fill_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_SCROLL_END;
            end
         end

         // last copy write, then blank the bottom row
         ST_SCROLL_END: begin
            fill_addr_in = ADDR_W'((ROWS - 1) * COLUMNS);
            fill_last_in = ADDR_W'(CELL_COUNT - 1);
            state_in     = ST_FILL;
         end

         // load the response once the output register is free
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               rsp_lin_in   = cell_lin(cur_row_ff, cur_col_ff);
               rsp_word_in  = word_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         text_attr_ff <= RESET_ATTR;
         fill_addr_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         fill_addr_ff <= fill_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            text_attr_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      char_ff      <= char_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      attr_ff      <= attr_in;
      word_ff      <= word_in;
      fill_last_ff <= fill_last_in;
      pend_addr_ff <= pend_addr_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_lin_ff   <= rsp_lin_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // response outputs
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_cell_word     = rsp_word_ff;

endmodule
